[sv/bcg_pkg.sv]
// Shared types, constants and voltage tables of the battery charge gauge.
package bcg_pkg;

    localparam int TABLE_ROWS_DEF = 12;
    localparam int MAX_ROWS       = 16;
    localparam int ROW_IDX_W      = 4;
    localparam int MV_W           = 16;
    localparam int PCT_W          = 7;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int DIV_NUM_W      = 24;
    localparam int DIV_DEN_W      = 16;
    localparam int QUOT_W         = 7;

    localparam logic [15:0] CAPACITY_RST   = 16'd8000;
    localparam logic [15:0] CONFIRM_RST    = 16'd30;
    localparam logic [6:0]  THRESHOLD_RST  = 7'd75;
    localparam logic [9:0]  COMP_RST       = 10'd40;
    localparam logic [14:0] FULL_CUR_RST   = 15'd150;
    localparam logic [14:0] EMPTY_CUR_RST  = 15'd100;

    localparam logic [6:0] FULL_SOC  = 7'd90;
    localparam logic [6:0] SOC_MAX   = 7'd100;
    localparam logic [6:0] PCT_SCALE = 7'd100;

    localparam logic [6:0] LEVEL_STEP [9] = '{
        7'd99, 7'd85, 7'd71, 7'd57, 7'd43, 7'd29, 7'd14, 7'd5, 7'd0
    };

    typedef enum logic [2:0] {
        CFG_CAPACITY  = 3'd0,
        CFG_CONFIRM   = 3'd1,
        CFG_THRESHOLD = 3'd2,
        CFG_COMP      = 3'd3,
        CFG_FULL_CUR  = 3'd4,
        CFG_EMPTY_CUR = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV_INTERP,
        ST_UPDATE,
        ST_DIV_PCT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [15:0] vmin;
        logic [15:0] vmax;
        logic [6:0]  smin;
        logic [6:0]  smax;
    } t_row;

    function automatic t_row table_row(input logic chg, input logic [3:0] idx);
        t_row r;
        r = '0;
        if (chg) begin
            case (idx)
                4'd0:    r = '{16'd21900, 16'd23999, 7'd100, 7'd100};
                4'd1:    r = '{16'd20526, 16'd21899, 7'd90,  7'd100};
                4'd2:    r = '{16'd20442, 16'd20525, 7'd80,  7'd90};
                4'd3:    r = '{16'd20406, 16'd20441, 7'd70,  7'd80};
                4'd4:    r = '{16'd20286, 16'd20405, 7'd60,  7'd70};
                4'd5:    r = '{16'd20196, 16'd20285, 7'd50,  7'd60};
                4'd6:    r = '{16'd20160, 16'd20195, 7'd40,  7'd50};
                4'd7:    r = '{16'd20124, 16'd20159, 7'd30,  7'd40};
                4'd8:    r = '{16'd19938, 16'd20123, 7'd20,  7'd30};
                4'd9:    r = '{16'd19632, 16'd19937, 7'd10,  7'd20};
                4'd10:   r = '{16'd12300, 16'd19631, 7'd0,   7'd10};
                4'd11:   r = '{16'd0,     16'd12299, 7'd0,   7'd0};
                default: r = '0;
            endcase
        end else begin
            case (idx)
                4'd0:    r = '{16'd19956, 16'd23999, 7'd100, 7'd100};
                4'd1:    r = '{16'd19500, 16'd19955, 7'd90,  7'd100};
                4'd2:    r = '{16'd19452, 16'd19499, 7'd80,  7'd90};
                4'd3:    r = '{16'd19380, 16'd19439, 7'd70,  7'd80};
                4'd4:    r = '{16'd19296, 16'd19379, 7'd60,  7'd70};
                4'd5:    r = '{16'd19230, 16'd19295, 7'd50,  7'd60};
                4'd6:    r = '{16'd19158, 16'd19229, 7'd40,  7'd50};
                4'd7:    r = '{16'd19056, 16'd19157, 7'd30,  7'd40};
                4'd8:    r = '{16'd18876, 16'd19055, 7'd20,  7'd30};
                4'd9:    r = '{16'd18504, 16'd18875, 7'd10,  7'd20};
                4'd10:   r = '{16'd12300, 16'd18503, 7'd0,   7'd10};
                4'd11:   r = '{16'd0,     16'd12599, 7'd0,   7'd0};
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [3:0] level_of(input logic [6:0] pct);
        logic [3:0] lvl;
        logic       found;
        lvl   = 4'd0;
        found = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (!found && pct > LEVEL_STEP[i]) begin
                lvl   = 4'(9 - i);
                found = 1'b1;
            end
        end
        return lvl;
    endfunction

endpackage

[sv/bcg_div.sv]
// Shared restoring divider producing a short quotient, one bit per cycle.
module bcg_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bcg_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [bcg_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [bcg_pkg::QUOT_W-1:0]     o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [2:0]                    r_step;
    logic [bcg_pkg::DIV_NUM_W-1:0] r_acc;
    logic [bcg_pkg::DIV_DEN_W-1:0] r_den;
    logic [bcg_pkg::QUOT_W-1:0]    r_quot;
    logic [bcg_pkg::DIV_NUM_W-1:0] trial;
    logic                          fits;

    always_comb begin
        trial = bcg_pkg::DIV_NUM_W'(r_den) << r_step;
        fits  = (r_acc >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
            r_step <= 3'(bcg_pkg::QUOT_W - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_acc <= r_acc - trial;
            end
            r_quot <= {r_quot[bcg_pkg::QUOT_W-2:0], fits};
            if (r_step != 3'd0) begin
                r_step <= r_step - 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[sv/battery_charge_gauge_top.sv]
// Top level of the battery charge gauge: sequencer, gauge state and stream ports.
//
// One item on the slave stream is one gauge tick: stack voltage, pack current
// and charge delta in s_axis_tdata, the charging flag in s_axis_tuser. The
// block answers each tick with one item on the master stream carrying the
// counted percent, the coarse level, the voltage-based percent and the
// confirmed full and empty flags.
// From acceptance to its result being offered, a tick runs through the table
// search, which visits one row per cycle, then the shared divider works out
// the interpolation (unless the row has no span or no row holds the voltage)
// and then the percent. The input is ready only while the sequencer is idle,
// so the next tick is taken no earlier than the cycle the last result is offered.
// The result sits in an output register, so the next tick is accepted while
// it waits; a stalled receiver holds the sequencer in its last step once a
// second result is ready.
// Configuration writes are always accepted and take effect at once; write
// them only while no tick is in flight.
// Reset loads the configuration defaults, clears the charge, the counters
// and the flags, and drops the output valid.
module battery_charge_gauge_top #(
    parameter int TABLE_ROWS = bcg_pkg::TABLE_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // stack_mv[15:0], pack_current_ma[31:16], charge_delta[47:32]
    input  logic [47:0]                     s_axis_tdata,
    // charging[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // soc_percent[6:0], charge_level[10:7], voltage_soc[17:11],
    // is_full[18], is_empty[19], zero fill [23:20]
    output logic [23:0]                     m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bcg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NROWS = (TABLE_ROWS > bcg_pkg::MAX_ROWS) ? bcg_pkg::MAX_ROWS : TABLE_ROWS;
    localparam logic [bcg_pkg::ROW_IDX_W-1:0] LAST_ROW = bcg_pkg::ROW_IDX_W'(NROWS - 1);

    bcg_pkg::t_state r_state, n_state;

    logic [15:0] r_cap, r_confirm;
    logic [6:0]  r_thr;
    logic [9:0]  r_comp;
    logic [14:0] r_full_cur, r_empty_cur;

    logic [15:0] r_remaining, n_remaining;
    logic [6:0]  r_last_pct, n_last_pct;
    logic [15:0] r_full_count, n_full_count;
    logic [15:0] r_empty_count, n_empty_count;
    logic        r_full, n_full;
    logic        r_empty, n_empty;
    logic [bcg_pkg::ROW_IDX_W-1:0] r_row, n_row;
    logic        r_out_valid, n_out_valid;

    logic [15:0] r_mv;
    logic        r_chg;
    logic [15:0] r_cur;
    logic [15:0] r_delta;
    logic [6:0]  r_smin, n_smin;
    logic [6:0]  r_vsoc, n_vsoc;
    logic [19:0] r_out_data, n_out_data;

    logic                          div_start;
    logic [bcg_pkg::DIV_NUM_W-1:0] div_num;
    logic [bcg_pkg::DIV_DEN_W-1:0] div_den;
    logic                          div_done;
    logic [bcg_pkg::QUOT_W-1:0]    div_quot;

    bcg_pkg::t_row      row;
    logic               hit;
    logic [15:0]        span;
    logic [6:0]         dsoc;
    logic [22:0]        prod;
    logic signed [16:0] cur_x;
    logic [16:0]        acur;
    logic signed [8:0]  err;
    logic signed [8:0]  thr9;
    logic signed [18:0] rem_x;
    logic signed [18:0] cap_x;
    logic [15:0]        rem_new;
    logic [22:0]        pct_num;
    logic               full_cond, empty_cond;
    logic [6:0]         pct;

    bcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign s_axis_tready = (r_state == bcg_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_data};

    always_comb begin
        row   = bcg_pkg::table_row(r_chg, r_row);
        hit   = (r_mv >= row.vmin) && (r_mv <= row.vmax);
        span  = row.vmax - row.vmin;
        dsoc  = row.smax - row.smin;
        prod  = 23'(r_mv - row.vmin) * 23'(dsoc);

        cur_x = {r_cur[15], r_cur};
        acur  = cur_x[16] ? 17'(-cur_x) : cur_x;
        err   = $signed({2'b00, r_vsoc}) - $signed({2'b00, r_last_pct});
        thr9  = $signed({2'b00, r_thr});
        cap_x = $signed({3'b000, r_cap});

        full_cond  = r_chg && (r_vsoc >= bcg_pkg::FULL_SOC) && (acur < {2'b00, r_full_cur});
        empty_cond = !r_chg && (r_vsoc == 7'd0) && (acur < {2'b00, r_empty_cur});

        pct = (r_cap == 16'd0) ? 7'd0
            : (div_quot > bcg_pkg::SOC_MAX) ? bcg_pkg::SOC_MAX : div_quot;
    end

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_smin        = r_smin;
        n_vsoc        = r_vsoc;
        n_remaining   = r_remaining;
        n_last_pct    = r_last_pct;
        n_full_count  = r_full_count;
        n_empty_count = r_empty_count;
        n_full        = r_full;
        n_empty       = r_empty;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_data    = r_out_data;
        div_start     = 1'b0;
        div_num       = bcg_pkg::DIV_NUM_W'(prod);
        div_den       = span;
        rem_x         = '0;
        rem_new       = '0;
        pct_num       = '0;

        unique case (r_state)
            bcg_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_row   = '0;
                    n_state = bcg_pkg::ST_SEARCH;
                end
            end
            bcg_pkg::ST_SEARCH: begin
                if (hit) begin
                    if (span == 16'd0) begin
                        n_vsoc  = row.smax;
                        n_state = bcg_pkg::ST_UPDATE;
                    end else begin
                        n_smin    = row.smin;
                        div_start = 1'b1;
                        n_state   = bcg_pkg::ST_DIV_INTERP;
                    end
                end else if (r_row == LAST_ROW) begin
                    n_vsoc  = 7'd0;
                    n_state = bcg_pkg::ST_UPDATE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            bcg_pkg::ST_DIV_INTERP: begin
                if (div_done) begin
                    n_vsoc  = r_smin + div_quot;
                    n_state = bcg_pkg::ST_UPDATE;
                end
            end
            bcg_pkg::ST_UPDATE: begin
                rem_x = $signed({3'b000, r_remaining}) + $signed({{3{r_delta[15]}}, r_delta});

                if (full_cond) begin
                    n_full_count = r_full_count + 16'd1;
                    if (n_full_count > r_confirm) begin
                        n_full  = 1'b1;
                        n_empty = 1'b0;
                    end
                end else begin
                    n_full_count = '0;
                    n_full       = 1'b0;
                end
                if (empty_cond) begin
                    n_empty_count = r_empty_count + 16'd1;
                    if (n_empty_count > r_confirm) begin
                        n_empty = 1'b1;
                        n_full  = 1'b0;
                    end
                end else begin
                    n_empty_count = '0;
                    n_empty       = 1'b0;
                end

                if (n_full) begin
                    rem_x = cap_x;
                end else if (n_empty) begin
                    rem_x = '0;
                end

                if (r_chg && (r_vsoc == bcg_pkg::SOC_MAX || err > thr9)) begin
                    rem_x = rem_x + $signed({9'd0, r_comp});
                end else if (!r_chg && (r_vsoc == 7'd0 || err < -thr9)) begin
                    rem_x = rem_x - $signed({9'd0, r_comp});
                end

                if (rem_x <= 0) begin
                    rem_new = 16'd0;
                end else if (rem_x >= cap_x) begin
                    rem_new = r_cap;
                end else begin
                    rem_new = rem_x[15:0];
                end
                n_remaining = rem_new;

                pct_num   = 23'(rem_new) * 23'(bcg_pkg::PCT_SCALE);
                div_num   = bcg_pkg::DIV_NUM_W'(pct_num);
                div_den   = r_cap;
                div_start = 1'b1;
                n_state   = bcg_pkg::ST_DIV_PCT;
            end
            bcg_pkg::ST_DIV_PCT: begin
                if (div_done) begin
                    n_last_pct = pct;
                    n_state    = bcg_pkg::ST_FINISH;
                end
            end
            bcg_pkg::ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_empty, r_full, r_vsoc,
                                   bcg_pkg::level_of(r_last_pct), r_last_pct};
                    n_state     = bcg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bcg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row         <= '0;
            r_remaining   <= '0;
            r_last_pct    <= '0;
            r_full_count  <= '0;
            r_empty_count <= '0;
            r_full        <= 1'b0;
            r_empty       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_row         <= n_row;
            r_remaining   <= n_remaining;
            r_last_pct    <= n_last_pct;
            r_full_count  <= n_full_count;
            r_empty_count <= n_empty_count;
            r_full        <= n_full;
            r_empty       <= n_empty;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= bcg_pkg::CAPACITY_RST;
            r_confirm   <= bcg_pkg::CONFIRM_RST;
            r_thr       <= bcg_pkg::THRESHOLD_RST;
            r_comp      <= bcg_pkg::COMP_RST;
            r_full_cur  <= bcg_pkg::FULL_CUR_RST;
            r_empty_cur <= bcg_pkg::EMPTY_CUR_RST;
        end else if (i_cfg_valid) begin
            unique case (bcg_pkg::t_cfg_reg'(i_cfg_index))
                bcg_pkg::CFG_CAPACITY:  r_cap       <= i_cfg_data;
                bcg_pkg::CFG_CONFIRM:   r_confirm   <= i_cfg_data;
                bcg_pkg::CFG_THRESHOLD: r_thr       <= i_cfg_data[6:0];
                bcg_pkg::CFG_COMP:      r_comp      <= i_cfg_data[9:0];
                bcg_pkg::CFG_FULL_CUR:  r_full_cur  <= i_cfg_data[14:0];
                bcg_pkg::CFG_EMPTY_CUR: r_empty_cur <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mv    <= s_axis_tdata[15:0];
            r_cur   <= s_axis_tdata[31:16];
            r_delta <= s_axis_tdata[47:32];
            r_chg   <= s_axis_tuser;
        end
        r_smin     <= n_smin;
        r_vsoc     <= n_vsoc;
        r_out_data <= n_out_data;
    end

endmodule

[tb/battery_charge_gauge_checker.sv]
`timescale 1ns / 1ps
// Checker for the battery charge gauge: predicts each tick's result and compares it.
module battery_charge_gauge_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [47:0]                    s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [23:0]                    m_axis_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic       is_empty;
        logic       is_full;
        logic [6:0] voltage_soc;
        logic [3:0] charge_level;
        logic [6:0] soc_percent;
    } t_gauge_result;

    typedef struct packed {
        int vmin;
        int vmax;
        int smin;
        int smax;
    } t_span;

    logic [15:0]   capacity;
    logic [15:0]   confirm;
    logic [6:0]    threshold;
    logic [9:0]    comp_step;
    logic [14:0]   full_cur;
    logic [14:0]   empty_cur;
    logic [15:0]   remaining;
    logic [6:0]    last_pct;
    logic [15:0]   full_count;
    logic [15:0]   empty_count;
    logic          full_flag;
    logic          empty_flag;
    t_gauge_result results_due[$];
    int            mismatches = 0;

    function automatic t_span span_of(input logic chg, input int idx);
        t_span s;
        s = '0;
        if (chg) begin
            case (idx)
                0:  s = '{3650 * 6, 4000 * 6 - 1, 100, 100};
                1:  s = '{3421 * 6, 3650 * 6 - 1, 90, 100};
                2:  s = '{3407 * 6, 3421 * 6 - 1, 80, 90};
                3:  s = '{3401 * 6, 3407 * 6 - 1, 70, 80};
                4:  s = '{3381 * 6, 3401 * 6 - 1, 60, 70};
                5:  s = '{3366 * 6, 3381 * 6 - 1, 50, 60};
                6:  s = '{3360 * 6, 3366 * 6 - 1, 40, 50};
                7:  s = '{3354 * 6, 3360 * 6 - 1, 30, 40};
                8:  s = '{3323 * 6, 3354 * 6 - 1, 20, 30};
                9:  s = '{3272 * 6, 3323 * 6 - 1, 10, 20};
                10: s = '{2050 * 6, 3272 * 6 - 1, 0, 10};
                11: s = '{0, 2050 * 6 - 1, 0, 0};
                default: s = '0;
            endcase
        end else begin
            case (idx)
                0:  s = '{3326 * 6, 4000 * 6 - 1, 100, 100};
                1:  s = '{3250 * 6, 3326 * 6 - 1, 90, 100};
                2:  s = '{3242 * 6, 3250 * 6 - 1, 80, 90};
                3:  s = '{3230 * 6, 3240 * 6 - 1, 70, 80};
                4:  s = '{3216 * 6, 3230 * 6 - 1, 60, 70};
                5:  s = '{3205 * 6, 3216 * 6 - 1, 50, 60};
                6:  s = '{3193 * 6, 3205 * 6 - 1, 40, 50};
                7:  s = '{3176 * 6, 3193 * 6 - 1, 30, 40};
                8:  s = '{3146 * 6, 3176 * 6 - 1, 20, 30};
                9:  s = '{3084 * 6, 3146 * 6 - 1, 10, 20};
                10: s = '{2050 * 6, 3084 * 6 - 1, 0, 10};
                11: s = '{0, 2100 * 6 - 1, 0, 0};
                default: s = '0;
            endcase
        end
        return s;
    endfunction

    // The first row holding the voltage wins; a voltage in no row reads as zero.
    function automatic int volt_soc(input logic [15:0] mv, input logic chg);
        t_span s;
        int    mvi;
        int    soc;
        int    hit;
        int    i;
        mvi = mv;
        soc = 0;
        hit = 0;
        for (i = 0; i < bcg_pkg::TABLE_ROWS_DEF; i++) begin
            s = span_of(chg, i);
            if (hit == 0 && mvi >= s.vmin && mvi <= s.vmax) begin
                hit = 1;
                if (s.vmax - s.vmin <= 0) begin
                    soc = s.smax;
                end else begin
                    soc = s.smin + ((mvi - s.vmin) * (s.smax - s.smin)) / (s.vmax - s.vmin);
                end
            end
        end
        return soc;
    endfunction

    task automatic predict_gauge_tick(input logic [15:0] mv, input logic chg,
                                      input logic signed [15:0] cur,
                                      input logic signed [15:0] delta,
                                      output t_gauge_result res);
        int vsoc;
        int rem;
        int dlt;
        int err;
        int acur;
        int cap;
        int thr;
        int comp;
        int fcur;
        int ecur;
        int pct;
        int lvl;
        int i;
        vsoc = volt_soc(mv, chg);
        acur = cur;
        if (acur < 0) acur = -acur;
        cap  = capacity;
        thr  = threshold;
        comp = comp_step;
        fcur = full_cur;
        ecur = empty_cur;
        rem  = remaining;
        dlt  = delta;
        rem  = rem + dlt;
        err  = last_pct;
        err  = vsoc - err;

        if (chg && vsoc >= int'(bcg_pkg::FULL_SOC) && acur < fcur) begin
            full_count = full_count + 16'd1;
            if (full_count > confirm) begin
                full_flag  = 1'b1;
                empty_flag = 1'b0;
            end
        end else begin
            full_count = '0;
            full_flag  = 1'b0;
        end
        if (!chg && vsoc == 0 && acur < ecur) begin
            empty_count = empty_count + 16'd1;
            if (empty_count > confirm) begin
                empty_flag = 1'b1;
                full_flag  = 1'b0;
            end
        end else begin
            empty_count = '0;
            empty_flag  = 1'b0;
        end

        if (full_flag) rem = cap;
        else if (empty_flag) rem = 0;

        if (chg && (vsoc == int'(bcg_pkg::SOC_MAX) || err > thr)) begin
            rem = rem + comp;
        end else if (!chg && (vsoc == 0 || err < -thr)) begin
            rem = rem - comp;
            if (rem < 0) rem = 0;
        end
        if (rem <= 0) rem = 0;
        if (rem >= cap) rem = cap;
        remaining = 16'(rem);

        pct = (cap > 0) ? (rem * 100) / cap : 0;
        if (pct > 100) pct = 100;
        last_pct = 7'(pct);

        lvl = 0;
        for (i = 8; i >= 0; i--) begin
            if (pct > int'(bcg_pkg::LEVEL_STEP[i])) lvl = 9 - i;
        end

        res.soc_percent  = 7'(pct);
        res.charge_level = 4'(lvl);
        res.voltage_soc  = 7'(vsoc);
        res.is_full      = full_flag;
        res.is_empty     = empty_flag;
    endtask

    always @(posedge i_clk) begin : watch
        t_gauge_result due;
        t_gauge_result seen;
        if (!i_rst_n) begin
            capacity    = bcg_pkg::CAPACITY_RST;
            confirm     = bcg_pkg::CONFIRM_RST;
            threshold   = bcg_pkg::THRESHOLD_RST;
            comp_step   = bcg_pkg::COMP_RST;
            full_cur    = bcg_pkg::FULL_CUR_RST;
            empty_cur   = bcg_pkg::EMPTY_CUR_RST;
            remaining   = '0;
            last_pct    = '0;
            full_count  = '0;
            empty_count = '0;
            full_flag   = 1'b0;
            empty_flag  = 1'b0;
            results_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (bcg_pkg::t_cfg_reg'(i_cfg_index))
                    bcg_pkg::CFG_CAPACITY:  capacity  = i_cfg_data[15:0];
                    bcg_pkg::CFG_CONFIRM:   confirm   = i_cfg_data[15:0];
                    bcg_pkg::CFG_THRESHOLD: threshold = i_cfg_data[6:0];
                    bcg_pkg::CFG_COMP:      comp_step = i_cfg_data[9:0];
                    bcg_pkg::CFG_FULL_CUR:  full_cur  = i_cfg_data[14:0];
                    bcg_pkg::CFG_EMPTY_CUR: empty_cur = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata[19:0];
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: pct %0d lvl %0d vsoc %0d %s",
                                 seen.soc_percent, seen.charge_level, seen.voltage_soc,
                                 $sformatf("full %0b empty %0b", seen.is_full, seen.is_empty));
                    end
                end else begin
                    due = results_due.pop_front();
                    if (seen !== due) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected pct %0d lvl %0d vsoc %0d %s",
                                     due.soc_percent, due.charge_level, due.voltage_soc,
                                     $sformatf("full %0b empty %0b", due.is_full, due.is_empty));
                            $display("                 got      pct %0d lvl %0d vsoc %0d %s",
                                     seen.soc_percent, seen.charge_level, seen.voltage_soc,
                                     $sformatf("full %0b empty %0b", seen.is_full, seen.is_empty));
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_gauge_tick(s_axis_tdata[15:0], s_axis_tuser, s_axis_tdata[31:16],
                                   s_axis_tdata[47:32], due);
                results_due.push_back(due);
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= mismatches;
    end

endmodule

[tb/battery_charge_gauge_top_test.sv]
`timescale 1ns / 1ps
// Testbench top for the battery charge gauge: drives ticks and settings, gives the verdict.
module battery_charge_gauge_top_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 50;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [47:0]                    s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [23:0]                    m_axis_tdata;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bcg_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bcg_pkg::CFG_DATA_W-1:0] i_cfg_data;
    int                             fail_count;
    int                             pending;
    int                             cycle_count;
    bit                             no_gaps = 1'b0;
    int                             cap_now;
    int                             confirm_now;
    int                             full_lim;
    int                             empty_lim;
    int                             phase_items;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    battery_charge_gauge_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    battery_charge_gauge_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    task automatic send_tick(input logic [15:0] mv, input logic chg,
                             input logic [15:0] cur, input logic [15:0] delta);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {delta, cur, mv};
        s_axis_tuser  <= chg;
        do @(posedge i_clk); while (!s_axis_tready);
        phase_items++;
    endtask

    task automatic settle(input int extra);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input bcg_pkg::t_cfg_reg idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Bits above a register's width are filled at random; the block drops them.
    task automatic load_setting(input int cap, input int conf, input int thr,
                                input int comp, input int fcur, input int ecur);
        write_reg(bcg_pkg::CFG_CAPACITY, 16'(cap));
        write_reg(bcg_pkg::CFG_CONFIRM, 16'(conf));
        write_reg(bcg_pkg::CFG_THRESHOLD, {9'($urandom), 7'(thr)});
        write_reg(bcg_pkg::CFG_COMP, {6'($urandom), 10'(comp)});
        write_reg(bcg_pkg::CFG_FULL_CUR, {1'($urandom), 15'(fcur)});
        write_reg(bcg_pkg::CFG_EMPTY_CUR, {1'($urandom), 15'(ecur)});
        cap_now     = cap & 16'hFFFF;
        confirm_now = conf & 16'hFFFF;
        full_lim    = fcur & 15'h7FFF;
        empty_lim   = ecur & 15'h7FFF;
    endtask

    function automatic logic [15:0] quiet_current(input int lim);
        int mag;
        if (lim > 0 && $urandom_range(0, 7) != 0) mag = $urandom_range(0, lim - 1);
        else mag = $urandom_range(lim, 32767);
        if ($urandom_range(0, 1)) mag = -mag;
        return 16'(mag);
    endfunction

    function automatic logic [15:0] drift(input int up);
        int span;
        span = cap_now / 8 + 2;
        return up ? 16'($urandom_range(0, span) - span / 4)
                  : 16'($urandom_range(0, span) - (3 * span) / 4);
    endfunction

    task automatic full_run(input int len);
        logic [15:0] mv;
        int          k;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) mv = 16'($urandom_range(19000, 20525));
            else mv = 16'($urandom_range(20526, 23999));
            send_tick(mv, 1'b1, quiet_current(full_lim), drift(1));
        end
    endtask

    task automatic empty_run(input int len);
        logic [15:0] mv;
        int          k;
        int          pick;
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) mv = 16'($urandom_range(19440, 19451));
            else if (pick == 1) mv = 16'($urandom_range(24000, 65535));
            else if (pick == 2) mv = 16'($urandom_range(12300, 19000));
            else mv = 16'($urandom_range(0, 12299));
            send_tick(mv, 1'b0, quiet_current(empty_lim), drift(0));
        end
    endtask

    task automatic noise_run(input int len);
        logic [15:0] mv;
        logic [15:0] delta;
        int          k;
        for (k = 0; k < len; k++) begin
            mv    = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(18000, 24500));
            delta = $urandom_range(0, 1) ? 16'($urandom) : drift($urandom_range(0, 1));
            send_tick(mv, 1'($urandom), 16'($urandom), delta);
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : receiver
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin : stimulus
        int phase;
        int pick;
        int run_cap;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= bcg_pkg::CFG_CAPACITY;
        i_cfg_data    <= '0;
        cap_now       = bcg_pkg::CAPACITY_RST;
        confirm_now   = bcg_pkg::CONFIRM_RST;
        full_lim      = bcg_pkg::FULL_CUR_RST;
        empty_lim     = bcg_pkg::EMPTY_CUR_RST;
        phase_items   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Table edges, the discharge gap, voltages above every row and field extremes.
        send_tick(16'd0, 1'b0, 16'd0, 16'd0);
        send_tick(16'hFFFF, 1'b1, 16'h7FFF, 16'h7FFF);
        send_tick(16'd24000, 1'b0, 16'h8000, 16'h8000);
        send_tick(16'd23999, 1'b1, 16'd0, 16'd100);
        send_tick(16'd23999, 1'b0, 16'd5, 16'd0);
        send_tick(16'd19440, 1'b0, 16'd0, 16'd0);
        send_tick(16'd19451, 1'b0, 16'd0, 16'd300);
        send_tick(16'd19452, 1'b0, 16'd0, 16'd0);
        send_tick(16'd19439, 1'b0, 16'd0, 16'd0);
        send_tick(16'd21899, 1'b1, 16'd0, 16'd4000);
        send_tick(16'd21900, 1'b1, 16'd0, 16'd0);
        send_tick(16'd12299, 1'b1, 16'd0, 16'd0);
        send_tick(16'd12300, 1'b1, 16'd0, 16'd0);
        send_tick(16'd12599, 1'b0, 16'd0, 16'd0);
        send_tick(16'd19955, 1'b0, 16'd0, 16'd0);
        send_tick(16'd20000, 1'b1, -16'sd149, 16'd500);
        send_tick(16'd100, 1'b0, -16'sd99, -16'sd500);
        send_tick(16'd100, 1'b0, 16'd100, 16'd0);

        for (phase = 0; phase < PHASES; phase++) begin
            settle(2);
            case (phase)
                0: load_setting(1, 0, 0, 0, 0, 0);
                1: load_setting(65535, 65535, 127, 1023, 32767, 32767);
                2: load_setting(0, 2, 100, 1023, 32767, 32767);
                default: begin
                    load_setting(
                        ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 65535))
                                                     : int'($urandom_range(100, 10000)),
                        ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                                     : int'($urandom_range(0, 12)),
                        ($urandom_range(0, 4) == 0) ? int'($urandom_range(101, 127))
                                                     : int'($urandom_range(0, 100)),
                        $urandom_range(0, 1023),
                        ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32767))
                                                     : int'($urandom_range(0, 600)),
                        ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32767))
                                                     : int'($urandom_range(0, 600)));
                end
            endcase
            no_gaps     = (phase % 4 == 3);
            run_cap     = (confirm_now + 4 < 40) ? confirm_now + 4 : 40;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) full_run($urandom_range(1, run_cap));
                else if (pick < 7) empty_run($urandom_range(1, run_cap));
                else noise_run($urandom_range(1, 5));
            end
        end

        settle(DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bcg_pkg.sv
sv/bcg_div.sv
sv/battery_charge_gauge_top.sv
tb/battery_charge_gauge_checker.sv
tb/battery_charge_gauge_top_test.sv
